// ===== hdl/mfpwm_pkg.sv =====
// Shared types and constants for the multichannel fan PWM unit.
// Holds the request and response structs, operation codes and the judge threshold function.
// No dependencies.
package mfpwm_pkg;

    localparam int NUM_FANS  = 28;
    localparam int CH_W      = 5;
    localparam int IDX_W     = $clog2(NUM_FANS);
    localparam int CNT_W     = $clog2(NUM_FANS + 1);
    localparam int DUTY_W    = 8;
    localparam int CUR_W     = 16;

    localparam logic [DUTY_W-1:0] PWM_TOP_RESET = 8'd250;
    localparam logic [DUTY_W-1:0] DUTY_FULL     = 8'hff;
    localparam logic [DUTY_W-1:0] DUTY_HALF     = 8'h7f;

    localparam logic [2:0] OP_TICK        = 3'd0;
    localparam logic [2:0] OP_SET_SPEED   = 3'd1;
    localparam logic [2:0] OP_FORCE_SPEED = 3'd2;
    localparam logic [2:0] OP_SET_ALL     = 3'd3;
    localparam logic [2:0] OP_START_INSP  = 3'd4;
    localparam logic [2:0] OP_JUDGE       = 3'd5;
    localparam logic [2:0] OP_READ_FAULT  = 3'd6;

    localparam logic [1:0] MODE_OFF  = 2'd0;
    localparam logic [1:0] MODE_FULL = 2'd1;
    localparam logic [1:0] MODE_HALF = 2'd2;

    typedef struct packed {
        logic [2:0]        operation;
        logic [CH_W-1:0]   channel;
        logic [DUTY_W-1:0] duty;
        logic [1:0]        all_mode;
        logic [CUR_W-1:0]  first_current;
        logic [CUR_W-1:0]  last_current;
        logic [CH_W-1:0]   fault_index;
    } t_req;

    typedef struct packed {
        logic [NUM_FANS-1:0] fan_drive;
        logic [CNT_W-1:0]    fault_count;
        logic [CNT_W-1:0]    fault_entry;
        logic [NUM_FANS-1:0] healthy_mask;
    } t_rsp;

    // Required current drop, chosen by the level of the first sample.
    function automatic logic [CUR_W-1:0] judge_threshold(input logic [CUR_W-1:0] first);
        logic [CUR_W-1:0] thr;
        if (first > 16'd7000) begin
            thr = 16'd3000;
        end else if (first > 16'd5000) begin
            thr = 16'd500;
        end else if (first > 16'd2200) begin
            thr = 16'd350;
        end else begin
            thr = 16'd10000;
        end
        return thr;
    endfunction

endpackage

// ===== hdl/mfpwm_judge.sv =====
// Pass/fail decision for one fan from two group-current samples.
// Depends on mfpwm_pkg for widths and the threshold function.
module mfpwm_judge import mfpwm_pkg::*; (
    input  logic [CUR_W-1:0] i_first,
    input  logic [CUR_W-1:0] i_last,
    output logic             o_pass
);

    logic [CUR_W-1:0] drop;
    logic [CUR_W-1:0] thr;

    // The subtraction is only meaningful when first exceeds last; the gate covers that.
    assign drop   = i_first - i_last;
    assign thr    = judge_threshold(i_first);
    assign o_pass = (i_first > i_last) && (drop > thr);

endmodule

// ===== hdl/mfpwm_core.sv =====
// Architectural state of the fan PWM unit and its request execution.
// Depends on mfpwm_pkg and mfpwm_judge.
module mfpwm_core import mfpwm_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [DUTY_W-1:0] i_cfg_data,
    input  logic              i_exec,
    input  t_req              i_req,
    output t_rsp              o_rsp
);

    localparam logic [CNT_W-1:0] COUNT_MAX = CNT_W'(NUM_FANS);

    logic [DUTY_W-1:0]   r_pwm_top;
    logic [DUTY_W-1:0]   r_pwm_count, n_pwm_count;
    logic [DUTY_W-1:0]   r_duty [NUM_FANS];
    logic [DUTY_W-1:0]   n_duty [NUM_FANS];
    logic [NUM_FANS-1:0] r_drive, n_drive;
    logic [NUM_FANS-1:0] r_health, n_health;
    logic [CNT_W-1:0]    r_list [NUM_FANS];
    logic [CNT_W-1:0]    r_count, n_count;
    logic                list_we;
    logic                ch_ok;
    logic                judge_pass;
    logic [CNT_W-1:0]    entry;

    mfpwm_judge u_judge (
        .i_first (i_req.first_current),
        .i_last  (i_req.last_current),
        .o_pass  (judge_pass)
    );

    assign ch_ok = int'(i_req.channel) < NUM_FANS;

    always_comb begin
        n_pwm_count = r_pwm_count;
        n_duty      = r_duty;
        n_drive     = r_drive;
        n_health    = r_health;
        n_count     = r_count;
        list_we     = 1'b0;
        case (i_req.operation)
            OP_TICK: begin
                if (r_pwm_count < r_pwm_top) begin
                    n_pwm_count = r_pwm_count + DUTY_W'(1);
                end else begin
                    n_pwm_count = '0;
                end
                for (int i = 0; i < NUM_FANS; i++) begin
                    n_drive[i] = n_pwm_count < r_duty[i];
                end
            end
            OP_SET_SPEED: begin
                if (ch_ok && r_health[i_req.channel[IDX_W-1:0]]) begin
                    n_duty[i_req.channel[IDX_W-1:0]] = i_req.duty;
                end
            end
            OP_FORCE_SPEED: begin
                if (ch_ok) begin
                    n_duty[i_req.channel[IDX_W-1:0]] = i_req.duty;
                end
            end
            OP_SET_ALL: begin
                for (int i = 0; i < NUM_FANS; i++) begin
                    if (i_req.all_mode == MODE_OFF) begin
                        n_duty[i] = '0;
                    end else if (i_req.all_mode == MODE_FULL && r_health[i]) begin
                        n_duty[i] = DUTY_FULL;
                    end else if (i_req.all_mode == MODE_HALF && r_health[i]) begin
                        n_duty[i] = DUTY_HALF;
                    end
                end
            end
            OP_START_INSP: begin
                // Fault list entries at or beyond the count read as empty, so only the count clears.
                for (int i = 0; i < NUM_FANS; i++) begin
                    n_duty[i] = '0;
                end
                n_count = '0;
            end
            OP_JUDGE: begin
                if (ch_ok) begin
                    if (judge_pass) begin
                        n_health[i_req.channel[IDX_W-1:0]] = 1'b1;
                    end else begin
                        n_health[i_req.channel[IDX_W-1:0]] = 1'b0;
                        if (r_count < COUNT_MAX) begin
                            list_we = 1'b1;
                            n_count = r_count + CNT_W'(1);
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Read of the fault list; positions at or beyond the count are empty.
    always_comb begin
        entry = '0;
        if (i_req.operation == OP_READ_FAULT && CNT_W'(i_req.fault_index) < r_count) begin
            entry = r_list[i_req.fault_index[IDX_W-1:0]];
        end
    end

    assign o_rsp.fan_drive    = n_drive;
    assign o_rsp.fault_count  = n_count;
    assign o_rsp.fault_entry  = entry;
    assign o_rsp.healthy_mask = n_health;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pwm_top <= PWM_TOP_RESET;
        end else if (i_cfg_we) begin
            r_pwm_top <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pwm_count <= '0;
            r_drive     <= '0;
            r_health    <= '0;
            r_count     <= '0;
            for (int i = 0; i < NUM_FANS; i++) begin
                r_duty[i] <= '0;
            end
        end else if (i_exec) begin
            r_pwm_count <= n_pwm_count;
            r_drive     <= n_drive;
            r_health    <= n_health;
            r_count     <= n_count;
            r_duty      <= n_duty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_exec && list_we) begin
            r_list[r_count[IDX_W-1:0]] <= CNT_W'(i_req.channel) + CNT_W'(1);
        end
    end

endmodule

// ===== hdl/multichannel_fan_pwm_with_fault_check_unit.sv =====
// Multichannel fan PWM unit with current-drop fault check: top level and handshake.
// A request accepted into the input register executes once the output register is free;
// its response is then registered and offered. Throughput: one request per cycle unless
// the output stalls. Reset (synchronous, active low) clears counter, duties, drive and
// health bits, fault count and both pipeline valid flags; pwm_top returns to 250.
// Depends on mfpwm_pkg, mfpwm_core.
module multichannel_fan_pwm_with_fault_check_unit import mfpwm_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_req              i_in_req,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_rsp              o_out_rsp,
    input  logic              i_cfg_we,
    input  logic [DUTY_W-1:0] i_cfg_data
);

    // Input register: holds one request until the execute stage takes it.
    logic r_in_valid;
    t_req r_in_req;

    // Output register: holds one response until downstream takes it.
    logic r_out_valid;
    t_rsp r_out_rsp;

    logic in_take;
    logic exec;
    t_rsp core_rsp;

    // The held request executes whenever the output register is empty or is being
    // emptied this cycle. State is updated in the same cycle, so the next request sees it.
    assign exec       = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !exec;
    assign in_take    = i_in_valid && !o_in_stall;

    mfpwm_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_exec     (exec),
        .i_req      (r_in_req),
        .o_rsp      (core_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (exec) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_req <= i_in_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (exec) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec) begin
            r_out_rsp <= core_rsp;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out_rsp;

endmodule

// ===== tb/tb_multichannel_fan_pwm_with_fault_check_unit.sv =====
// Self-checking testbench for the multichannel fan PWM unit with current-drop fault check.
// Drives requests through the valid/stall handshake and checks every response against a
// behavioral predictor here or a fixed status. Depends on mfpwm_pkg and the unit under test.
module tb_multichannel_fan_pwm_with_fault_check_unit;
    import mfpwm_pkg::*;

    // Codes the package does not name: the unused operation and the do-nothing set_all mode.
    localparam logic [2:0] OP_RESERVED = 3'd7;
    localparam logic [1:0] MODE_NONE   = 2'd3;

    // A request passes the unit's input register and then its output register.
    localparam int PIPE_LAT     = 2;
    localparam int ITEM_TARGET  = 1300;
    localparam int HOLD_CYCLES  = 150;
    localparam int QUIET_LIMIT  = 1000;
    localparam int RETUNE_EVERY = 200;

    typedef struct {
        t_req req;
        bit   fixed;
        t_rsp want;
    } t_directed_row;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              in_stall;
    t_req              in_req    = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    t_rsp              out_rsp;
    logic              cfg_we    = 1'b0;
    logic [DUTY_W-1:0] cfg_data  = '0;

    multichannel_fan_pwm_with_fault_check_unit dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_req   (in_req),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_rsp  (out_rsp),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data)
    );

    always #5 clk = ~clk;

    // Predictor state: a private copy of everything the unit remembers.
    logic [DUTY_W-1:0]   top_setting = PWM_TOP_RESET;
    logic [DUTY_W-1:0]   pwm_phase   = '0;
    logic [DUTY_W-1:0]   duty_of [NUM_FANS];
    logic [NUM_FANS-1:0] drive_now   = '0;
    logic [NUM_FANS-1:0] healthy_now = '0;
    logic [CNT_W-1:0]    fault_log [NUM_FANS];
    logic [CNT_W-1:0]    fault_total = '0;

    t_rsp status_due [$];
    t_directed_row directed_rows [$];

    int  errors       = 0;
    int  sent         = 0;
    int  burst_left   = 0;
    int  quiet_cycles = 0;
    bit  hold_request = 1'b0;

    // Current drop that a fan must beat, chosen by the level of the first sample.
    function automatic int drop_needed(input int first_cur);
        if (first_cur > 7000) return 3000;
        if (first_cur > 5000) return 500;
        if (first_cur > 2200) return 350;
        return 10000;
    endfunction

    // Applies one request to the predictor state and returns the status it should produce.
    function automatic t_rsp next_fan_status(input t_req r);
        t_rsp             s;
        logic [CNT_W-1:0] entry;
        int               ch;
        int               fc;
        int               lc;
        entry = '0;
        ch    = int'(r.channel);
        fc    = int'(r.first_current);
        lc    = int'(r.last_current);
        case (r.operation)
            OP_TICK: begin
                pwm_phase = (pwm_phase < top_setting) ? pwm_phase + 8'd1 : 8'd0;
                for (int i = 0; i < NUM_FANS; i++) begin
                    drive_now[i] = pwm_phase < duty_of[i];
                end
            end
            OP_SET_SPEED: begin
                if (ch < NUM_FANS && healthy_now[ch]) duty_of[ch] = r.duty;
            end
            OP_FORCE_SPEED: begin
                if (ch < NUM_FANS) duty_of[ch] = r.duty;
            end
            OP_SET_ALL: begin
                for (int i = 0; i < NUM_FANS; i++) begin
                    if (r.all_mode == MODE_OFF) duty_of[i] = '0;
                    else if (r.all_mode == MODE_FULL && healthy_now[i]) duty_of[i] = DUTY_FULL;
                    else if (r.all_mode == MODE_HALF && healthy_now[i]) duty_of[i] = DUTY_HALF;
                end
            end
            OP_START_INSP: begin
                for (int i = 0; i < NUM_FANS; i++) begin
                    fault_log[i] = '0;
                    duty_of[i]   = '0;
                end
                fault_total = '0;
            end
            OP_JUDGE: begin
                if (ch < NUM_FANS) begin
                    if (fc > lc && fc - lc > drop_needed(fc)) begin
                        healthy_now[ch] = 1'b1;
                    end else begin
                        healthy_now[ch] = 1'b0;
                        if (fault_total < NUM_FANS) begin
                            fault_log[fault_total] = CNT_W'(ch + 1);
                            fault_total            = fault_total + CNT_W'(1);
                        end
                    end
                end
            end
            OP_READ_FAULT: begin
                if (r.fault_index < NUM_FANS) entry = fault_log[r.fault_index];
            end
            default: begin
            end
        endcase
        s.fan_drive    = drive_now;
        s.fault_count  = fault_total;
        s.fault_entry  = entry;
        s.healthy_mask = healthy_now;
        return s;
    endfunction

    function automatic t_req noise_req();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return raw[$bits(t_req)-1:0];
    endfunction

    // A request with the given operation; fields it does not use carry random noise.
    function automatic t_req cmd(input logic [2:0] op);
        t_req r;
        r           = noise_req();
        r.operation = op;
        return r;
    endfunction

    // Mostly a real fan, now and then a channel number past the last fan.
    function automatic int pick_fan();
        if ($urandom_range(0, 11) == 0) return $urandom_range(NUM_FANS, 31);
        return $urandom_range(0, NUM_FANS - 1);
    endfunction

    // Hands one request to the unit. The sender works in bursts; between bursts valid drops
    // for a random gap and the payload wanders, which the unit must ignore.
    task automatic present(input t_req r);
        int gap;
        if (burst_left <= 0) begin
            gap = $urandom_range(1, 8);
            @(negedge clk);
            in_valid <= 1'b0;
            in_req   <= noise_req();
            repeat (gap - 1) @(negedge clk);
            // Now and then a long burst, so that stretches without idling occur.
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 24);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_req   <= r;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        burst_left--;
        sent++;
    endtask

    task automatic offer(input t_req r);
        present(r);
        status_due.push_back(next_fan_status(r));
    endtask

    // Judge request whose currents sit on the intended side of the threshold when they can,
    // often right at its boundary.
    task automatic offer_judge(input int ch, input bit pass);
        t_req r;
        int   fc;
        int   lc;
        int   need;
        int   lvl;
        r         = cmd(OP_JUDGE);
        r.channel = CH_W'(ch);
        case ($urandom_range(0, 5))
            0: fc = $urandom_range(0, 2200);
            1: fc = $urandom_range(2201, 5000);
            2: fc = $urandom_range(5001, 7000);
            3: fc = $urandom_range(7001, 65535);
            4: begin
                lvl = $urandom_range(0, 2);
                fc  = (lvl == 0 ? 2200 : lvl == 1 ? 5000 : 7000) + $urandom_range(0, 1);
            end
            default: fc = $urandom_range(0, 1) ? 65535 : 0;
        endcase
        need = drop_needed(fc);
        if (pass && fc > need) begin
            lc = ($urandom_range(0, 2) == 0) ? fc - need - 1 : $urandom_range(0, fc - need - 1);
        end else if (!pass && fc >= need && $urandom_range(0, 1)) begin
            lc = fc - need;
        end else if (!pass) begin
            lc = $urandom_range(fc, 65535);
        end else begin
            lc = $urandom_range(0, 65535);
        end
        r.first_current = CUR_W'(fc);
        r.last_current  = CUR_W'(lc);
        offer(r);
    endtask

    task automatic offer_ticks(input int n);
        repeat (n) offer(cmd(OP_TICK));
    endtask

    // Stops sending and waits for every outstanding response.
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (status_due.size() != 0) @(posedge clk);
        burst_left = 0;
    endtask

    // Changes the PWM period; the unit must be idle, so everything is drained first.
    task automatic retune(input logic [DUTY_W-1:0] v);
        drain();
        repeat (PIPE_LAT) @(posedge clk);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(negedge clk);
        cfg_we   <= 1'b0;
        top_setting = v;
    endtask

    task automatic add_row(input logic [2:0] op, input int ch, input int duty,
                           input logic [1:0] mode, input int fc, input int lc,
                           input int idx, input bit fixed, input t_rsp want);
        t_directed_row row;
        row.req               = '0;
        row.req.operation     = op;
        row.req.channel       = CH_W'(ch);
        row.req.duty          = DUTY_W'(duty);
        row.req.all_mode      = mode;
        row.req.first_current = CUR_W'(fc);
        row.req.last_current  = CUR_W'(lc);
        row.req.fault_index   = CH_W'(idx);
        row.fixed             = fixed;
        row.want              = want;
        directed_rows.push_back(row);
    endtask

    task automatic compare_status(input t_rsp got, input t_rsp want);
        if (got.fan_drive !== want.fan_drive) begin
            $error("fan_drive: expected %h, got %h", want.fan_drive, got.fan_drive);
            errors++;
        end
        if (got.fault_count !== want.fault_count) begin
            $error("fault_count: expected %0d, got %0d", want.fault_count, got.fault_count);
            errors++;
        end
        if (got.fault_entry !== want.fault_entry) begin
            $error("fault_entry: expected %0d, got %0d", want.fault_entry, got.fault_entry);
            errors++;
        end
        if (got.healthy_mask !== want.healthy_mask) begin
            $error("healthy_mask: expected %h, got %h", want.healthy_mask, got.healthy_mask);
            errors++;
        end
    endtask

    // Response side: every accepted response is matched against the oldest expectation.
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (status_due.size() == 0) begin
                $error("unexpected response %h with nothing outstanding", out_rsp);
                errors++;
            end else begin
                compare_status(out_rsp, status_due.pop_front());
            end
        end
    end

    // Watchdog: ends the run when neither side has moved a request for too long.
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
            $display("multichannel_fan_pwm_with_fault_check_unit test failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Receiver stall pattern. It switches among a few styles in segments of random
    // length, and on request holds off for a long stretch so that the unit fills up
    // and has to stall its own input.
    initial begin
        int style;
        int len;
        int phase_ctr;
        phase_ctr = 0;
        forever begin
            style = $urandom_range(0, 3);
            len   = $urandom_range(20, 100);
            repeat (len) begin
                @(negedge clk);
                phase_ctr++;
                if (hold_request) begin
                    hold_request = 1'b0;
                    out_stall <= 1'b1;
                    repeat (HOLD_CYCLES - 1) @(negedge clk);
                end else begin
                    case (style)
                        0: out_stall <= 1'b0;
                        1: out_stall <= ($urandom_range(0, 3) == 0);
                        2: out_stall <= ($urandom_range(0, 3) != 0);
                        default: out_stall <= (phase_ctr % 8) < 3;
                    endcase
                end
            end
        end
    end

    initial begin
        t_req r;
        t_rsp predicted;
        int   pass_pct;
        int   retune_at;
        int   phase;
        bit   hold_done;
        logic [DUTY_W-1:0] new_top;

        for (int i = 0; i < NUM_FANS; i++) begin
            duty_of[i]   = '0;
            fault_log[i] = '0;
        end
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part, run with the reset PWM period. Rows marked fixed carry a status
        // that follows from reset values and the rows before; the rest go through the predictor.
        // Reads right after reset, in range and past the end of the list.
        add_row(OP_READ_FAULT, 0, 0, MODE_OFF, 0, 0, 0, 1'b1, '0);
        add_row(OP_READ_FAULT, 0, 0, MODE_OFF, 0, 0, 31, 1'b1, '0);
        add_row(OP_TICK, 0, 0, MODE_OFF, 0, 0, 0, 1'b1, '0);
        // A normal speed write to a fan that has not passed is dropped.
        add_row(OP_SET_SPEED, 0, 255, MODE_OFF, 0, 0, 0, 1'b1, '0);
        // A forced write lands, but the drive bit waits for the next tick.
        add_row(OP_FORCE_SPEED, 27, 255, MODE_OFF, 0, 0, 0, 1'b1, '0);
        add_row(OP_FORCE_SPEED, 31, 8'haa, MODE_OFF, 0, 0, 0, 1'b0, '0);
        add_row(OP_TICK, 0, 0, MODE_OFF, 0, 0, 0, 1'b1,
                {28'h800_0000, 5'd0, 5'd0, 28'h000_0000});
        // Judge boundaries around the band edges, mostly one count above and exactly at the limit.
        add_row(OP_JUDGE, 3, 0, MODE_OFF, 7001, 4000, 0, 1'b1,
                {28'h800_0000, 5'd0, 5'd0, 28'h000_0008});
        add_row(OP_JUDGE, 4, 0, MODE_OFF, 7001, 4001, 0, 1'b1,
                {28'h800_0000, 5'd1, 5'd0, 28'h000_0008});
        add_row(OP_JUDGE, 5, 0, MODE_OFF, 5001, 4500, 0, 1'b0, '0);
        add_row(OP_JUDGE, 6, 0, MODE_OFF, 5000, 4650, 0, 1'b0, '0);
        add_row(OP_JUDGE, 7, 0, MODE_OFF, 2201, 1850, 0, 1'b0, '0);
        add_row(OP_JUDGE, 8, 0, MODE_OFF, 2200, 0, 0, 1'b0, '0);
        // Equal samples and a rising current both fail.
        add_row(OP_JUDGE, 9, 0, MODE_OFF, 65535, 65535, 0, 1'b0, '0);
        add_row(OP_JUDGE, 10, 0, MODE_OFF, 0, 65535, 0, 1'b0, '0);
        add_row(OP_JUDGE, 31, 0, MODE_OFF, 65535, 0, 0, 1'b0, '0);
        add_row(OP_READ_FAULT, 0, 0, MODE_OFF, 0, 0, 1, 1'b0, '0);
        add_row(OP_SET_SPEED, 3, 8'h80, MODE_OFF, 0, 0, 0, 1'b0, '0);
        add_row(OP_SET_ALL, 0, 0, MODE_FULL, 0, 0, 0, 1'b0, '0);
        add_row(OP_SET_ALL, 0, 0, MODE_HALF, 0, 0, 0, 1'b0, '0);
        add_row(OP_SET_ALL, 0, 0, MODE_NONE, 0, 0, 0, 1'b0, '0);
        add_row(OP_RESERVED, 0, 0, MODE_OFF, 0, 0, 0, 1'b0, '0);
        add_row(OP_TICK, 0, 0, MODE_OFF, 0, 0, 0, 1'b0, '0);
        add_row(OP_SET_ALL, 0, 0, MODE_OFF, 0, 0, 0, 1'b0, '0);
        add_row(OP_TICK, 0, 0, MODE_OFF, 0, 0, 0, 1'b0, '0);
        // Inspection start keeps health bits; drive only changes at the next tick.
        add_row(OP_START_INSP, 0, 0, MODE_OFF, 0, 0, 0, 1'b0, '0);

        foreach (directed_rows[k]) begin
            present(directed_rows[k].req);
            predicted = next_fan_status(directed_rows[k].req);
            status_due.push_back(directed_rows[k].fixed ? directed_rows[k].want : predicted);
        end

        // Random part, built from well-formed inspection campaigns and PWM runs with
        // random content, mixed with raw noise. The PWM period changes every 200 requests or so
        // and visits both extremes as well as zero.
        retune_at = sent;
        phase     = 0;
        hold_done = 1'b0;
        while (sent < ITEM_TARGET) begin
            if (sent >= retune_at) begin
                case (phase % 6)
                    0: new_top = 8'd1;
                    1: new_top = 8'd255;
                    2: new_top = 8'd0;
                    3: new_top = 8'd3;
                    4: new_top = DUTY_W'($urandom_range(4, 254));
                    default: new_top = PWM_TOP_RESET;
                endcase
                retune(new_top);
                phase++;
                retune_at = sent + RETUNE_EVERY;
            end
            // One long receiver hold-off while the sender keeps offering back to back.
            if (!hold_done && sent >= 500) begin
                hold_done    = 1'b1;
                hold_request = 1'b1;
                burst_left   = 400;
            end
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    // Inspection campaign; fail-heavy ones can overflow the fault list.
                    offer(cmd(OP_START_INSP));
                    pass_pct = $urandom_range(5, 95);
                    repeat ($urandom_range(8, 64)) begin
                        offer_judge(pick_fan(), $urandom_range(1, 100) <= pass_pct);
                    end
                    repeat ($urandom_range(3, 10)) begin
                        r             = cmd(OP_READ_FAULT);
                        r.fault_index = CH_W'($urandom_range(0, 31));
                        offer(r);
                    end
                    offer(cmd(OP_SET_ALL));
                    repeat ($urandom_range(0, 4)) begin
                        r         = cmd(OP_SET_SPEED);
                        r.channel = CH_W'(pick_fan());
                        offer(r);
                    end
                    offer_ticks($urandom_range(5, 60));
                end
                4, 5, 6: begin
                    // Speed changes followed by a run of ticks.
                    repeat ($urandom_range(1, 6)) begin
                        r         = cmd($urandom_range(0, 1) ? OP_FORCE_SPEED : OP_SET_SPEED);
                        r.channel = CH_W'(pick_fan());
                        if ($urandom_range(0, 3) == 0) begin
                            r.duty = $urandom_range(0, 1) ? 8'hff : 8'h00;
                        end
                        offer(r);
                    end
                    offer_ticks($urandom_range(10, 80));
                end
                7: begin
                    repeat ($urandom_range(4, 12)) offer(noise_req());
                end
                default: begin
                    r = cmd(OP_SET_ALL);
                    offer(r);
                    offer_ticks($urandom_range(2, 30));
                end
            endcase
        end

        drain();
        repeat (PIPE_LAT + 8) @(posedge clk);
        if (errors == 0) begin
            $display("multichannel_fan_pwm_with_fault_check_unit test passed");
        end else begin
            $display("multichannel_fan_pwm_with_fault_check_unit test failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/mfpwm_pkg.sv
hdl/mfpwm_judge.sv
hdl/mfpwm_core.sv
hdl/multichannel_fan_pwm_with_fault_check_unit.sv
tb/tb_multichannel_fan_pwm_with_fault_check_unit.sv
